>>> src/png_row_unfilter_top_assert.svh
// Assertion macros used by the checker file of the row unfilter.
`ifndef PNG_ROW_UNFILTER_TOP_ASSERT_SVH
`define PNG_ROW_UNFILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define PRU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on every clock outside reset.
`define PRU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

>>> src/pru_pkg.sv
// Shared constants and types of the PNG row unfilter.
package pru_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int POS_W       = $clog2(STORE_DEPTH);
    localparam int STRIDE_W    = POS_W + 1;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int DIM_W       = 13;
    localparam int BPP_W       = 3;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(64);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(64);
    localparam logic [BPP_W-1:0] BPP_RESET    = BPP_W'(3);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_BPP    = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // Sample fields carried from the control stage to the reconstruct stage.
    typedef struct packed {
        logic [7:0]       raw;
        filter_t          filter;
        logic             bpp4;
        logic             left_ok;
        logic             row_nz;
        logic [1:0]       chan;
        logic             row_end;
        logic             img_end;
        logic             bad;
        logic [POS_W-1:0] pos;
    } s1_t;

endpackage

>>> src/pru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pru_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/png_row_unfilter_top.sv
// PNG scanline unfilter: undoes None/Sub/Up/Average/Paeth per row.
//
//  channel   dir  transaction                     payload
//  s_*       in   one inflated stream byte        s_stream_byte, s_image_start
//  m_*       out  one reconstructed sample/error  m_sample_value, m_channel_index,
//                                                 m_row_end, m_image_end, m_bad_filter
//  apb       in   register write / read           paddr, pwdata -> prdata
//
//  One byte per cycle sustained while m_ready does not stall. The control stage
//  and the line store read data register a byte at the edge that accepts it; the
//  add is combinational and the output register loads when the sample advances.
//  The line store is read one stage ahead of the add, so the only loop
//  between samples is the left-byte history inside the reconstruct stage.
//  Reset (aresetn low, synchronous) clears control state and loads register
//  defaults; the line store is not cleared and its read data is masked in row 0.
//  A stall on m_ready holds the output, the reconstruct stage and the RAM
//  read data; s_ready is low in the same cycle while the reconstruct stage is held.
module png_row_unfilter_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // stream input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_stream_byte,
    input  logic                        s_image_start,
    // sample output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_sample_value,
    output logic [1:0]                  m_channel_index,
    output logic                        m_row_end,
    output logic                        m_image_end,
    output logic                        m_bad_filter,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pru_pkg::PADDR_W-1:0] paddr,
    input  logic [pru_pkg::PDATA_W-1:0] pwdata,
    output logic [pru_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int POS_W    = pru_pkg::POS_W;
    localparam int STRIDE_W = pru_pkg::STRIDE_W;
    localparam int ROW_W    = pru_pkg::ROW_W;
    localparam int DIM_W    = pru_pkg::DIM_W;
    localparam int BPP_W    = pru_pkg::BPP_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [BPP_W-1:0]    bpp_reg;
    pru_pkg::reg_index_t preg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign preg      = pru_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pru_pkg::WIDTH_RESET;
            height_reg <= pru_pkg::HEIGHT_RESET;
            bpp_reg    <= pru_pkg::BPP_RESET;
        end else if (cfg_write) begin
            unique case (preg)
                pru_pkg::REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                pru_pkg::REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                pru_pkg::REG_BPP:    bpp_reg    <= pwdata[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (preg)
            pru_pkg::REG_WIDTH:  prdata = pru_pkg::PDATA_W'(width_reg);
            pru_pkg::REG_HEIGHT: prdata = pru_pkg::PDATA_W'(height_reg);
            pru_pkg::REG_BPP:    prdata = pru_pkg::PDATA_W'(bpp_reg);
            default:             prdata = '0;
        endcase
    end

    // Saturate the registers into their working ranges.
    logic [DIM_W-1:0]    width_sat;
    logic [DIM_W-1:0]    height_sat;
    logic                bpp4;
    logic [STRIDE_W-1:0] stride;

    always_comb begin
        if (width_reg == '0) begin
            width_sat = DIM_W'(1);
        end else if (width_reg > DIM_W'(pru_pkg::MAX_WIDTH)) begin
            width_sat = DIM_W'(pru_pkg::MAX_WIDTH);
        end else begin
            width_sat = width_reg;
        end
        if (height_reg == '0) begin
            height_sat = DIM_W'(1);
        end else if (height_reg > DIM_W'(pru_pkg::MAX_ROWS)) begin
            height_sat = DIM_W'(pru_pkg::MAX_ROWS);
        end else begin
            height_sat = height_reg;
        end
        bpp4   = (bpp_reg >= BPP_W'(4));
        stride = bpp4 ? (STRIDE_W'(width_sat) << 2)
                      : ((STRIDE_W'(width_sat) << 1) + STRIDE_W'(width_sat));
    end

    // ------------------------------------------------------------------
    // Control stage: row / position tracking at input acceptance
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [1:0]       mod3_reg,  mod3_next;
    logic [ROW_W-1:0] row_reg,   row_next;
    logic             await_reg, await_next;
    logic             error_reg, error_next;
    pru_pkg::filter_t filter_reg, filter_next;

    logic             s1_valid_reg;
    pru_pkg::s1_t     s1_reg, s1_next;
    logic             s1_adv;
    logic             in_accept;

    logic             err_eff, await_eff;
    logic [POS_W-1:0] pos_eff;
    logic [1:0]       mod3_eff;
    logic [ROW_W-1:0] row_eff;
    logic             last_in_row, last_row;
    logic             is_sample, is_bad, emit;

    logic             out_valid_reg;

    // Hold the control stage while the reconstruct stage cannot advance.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign in_accept = s_valid && s_ready;

    always_comb begin
        // Image start restarts the image before the byte is looked at.
        err_eff   = error_reg && !s_image_start;
        await_eff = await_reg || s_image_start;
        pos_eff   = s_image_start ? '0 : pos_reg;
        mod3_eff  = s_image_start ? '0 : mod3_reg;
        row_eff   = s_image_start ? '0 : row_reg;

        last_in_row = ((STRIDE_W'(pos_eff) + STRIDE_W'(1)) >= stride);
        last_row    = ((DIM_W'(row_eff) + DIM_W'(1)) >= height_sat);

        is_sample = !err_eff && !await_eff;
        is_bad    = !err_eff && await_eff && (s_stream_byte > 8'(pru_pkg::FILT_PAETH));
        emit      = is_sample || is_bad;

        pos_next    = pos_reg;
        mod3_next   = mod3_reg;
        row_next    = row_reg;
        await_next  = await_reg;
        error_next  = error_reg;
        filter_next = filter_reg;

        if (in_accept) begin
            if (s_image_start) begin
                pos_next   = '0;
                mod3_next  = '0;
                row_next   = '0;
                await_next = 1'b1;
                error_next = 1'b0;
            end
            if (!err_eff) begin
                if (await_eff) begin
                    if (is_bad) begin
                        error_next = 1'b1;
                    end else begin
                        filter_next = pru_pkg::filter_t'(s_stream_byte[2:0]);
                        await_next  = 1'b0;
                        pos_next    = '0;
                        mod3_next   = '0;
                    end
                end else if (last_in_row) begin
                    await_next = 1'b1;
                    pos_next   = '0;
                    mod3_next  = '0;
                    row_next   = last_row ? '0 : row_eff + ROW_W'(1);
                end else begin
                    pos_next  = pos_eff + POS_W'(1);
                    mod3_next = (mod3_eff == 2'd2) ? 2'd0 : mod3_eff + 2'd1;
                end
            end
        end

        s1_next.raw     = s_stream_byte;
        s1_next.filter  = filter_reg;
        s1_next.bpp4    = bpp4;
        s1_next.left_ok = bpp4 ? (pos_eff >= POS_W'(4)) : (pos_eff >= POS_W'(3));
        s1_next.row_nz  = (row_eff != '0);
        s1_next.chan    = bpp4 ? pos_eff[1:0] : mod3_eff;
        s1_next.row_end = is_sample && last_in_row;
        s1_next.img_end = is_sample && last_in_row && last_row;
        s1_next.bad     = is_bad;
        s1_next.pos     = pos_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            mod3_reg     <= '0;
            row_reg      <= '0;
            await_reg    <= 1'b1;
            error_reg    <= 1'b0;
            filter_reg   <= pru_pkg::FILT_NONE;
            s1_valid_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            mod3_reg   <= mod3_next;
            row_reg    <= row_next;
            await_reg  <= await_next;
            error_reg  <= error_next;
            filter_reg <= filter_next;
            if (in_accept) begin
                s1_valid_reg <= emit;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: read above-byte at acceptance, write result on advance
    // ------------------------------------------------------------------
    logic       ram_we;
    logic [7:0] above_raw;
    logic [7:0] x;

    assign ram_we = s1_adv && !s1_reg.bad;

    pru_ram #(
        .WIDTH (8),
        .DEPTH (pru_pkg::STORE_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_reg.pos),
        .wdata (x),
        .re    (in_accept && is_sample),
        .raddr (pos_eff),
        .rdata (above_raw)
    );

    // ------------------------------------------------------------------
    // Reconstruct stage
    // ------------------------------------------------------------------
    logic [31:0]        left_reg;
    logic [31:0]        upleft_reg;
    logic [7:0]         a, b, c, pred;
    logic [8:0]         avg_sum;
    logic signed [10:0] d_pa, d_pb, d_pc;
    logic [9:0]         pa, pb, pc;

    always_comb begin
        a = s1_reg.left_ok ? (s1_reg.bpp4 ? left_reg[31:24] : left_reg[23:16]) : 8'd0;
        b = s1_reg.row_nz ? above_raw : 8'd0;
        c = (s1_reg.row_nz && s1_reg.left_ok)
            ? (s1_reg.bpp4 ? upleft_reg[31:24] : upleft_reg[23:16]) : 8'd0;

        avg_sum = {1'b0, a} + {1'b0, b};

        // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
        d_pa = $signed({3'b0, b}) - $signed({3'b0, c});
        d_pb = $signed({3'b0, a}) - $signed({3'b0, c});
        d_pc = d_pa + d_pb;
        pa   = d_pa[10] ? 10'(-d_pa) : d_pa[9:0];
        pb   = d_pb[10] ? 10'(-d_pb) : d_pb[9:0];
        pc   = d_pc[10] ? 10'(-d_pc) : d_pc[9:0];

        case (s1_reg.filter)
            pru_pkg::FILT_SUB:   pred = a;
            pru_pkg::FILT_UP:    pred = b;
            pru_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pru_pkg::FILT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:             pred = 8'd0;
        endcase

        x = s1_reg.raw + pred;
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            left_reg   <= {left_reg[23:0], x};
            upleft_reg <= {upleft_reg[23:0], b};
        end
    end

    // Output register: load on advance, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_sample_value  <= s1_reg.bad ? 8'd0 : x;
            m_channel_index <= s1_reg.bad ? 2'd0 : s1_reg.chan;
            m_row_end       <= s1_reg.row_end;
            m_image_end     <= s1_reg.img_end;
            m_bad_filter    <= s1_reg.bad;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

>>> src/pru_checker.sv
// Port-level checker for the row unfilter, bound to the top level.
`include "png_row_unfilter_top_assert.svh"

module pru_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_stream_byte,
    input logic       s_image_start,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_sample_value,
    input logic [1:0] m_channel_index,
    input logic       m_row_end,
    input logic       m_image_end,
    input logic       m_bad_filter
);

    // An error result carries nothing but its flag.
    `PRU_ASSERT_NOW(a_bad_clean, aclk, aresetn, m_valid && m_bad_filter,
        m_sample_value == 8'd0 && m_channel_index == 2'd0 && !m_row_end && !m_image_end)

    // The last sample of an image also closes its row.
    `PRU_ASSERT_NOW(a_img_row_end, aclk, aresetn, m_valid && m_image_end, m_row_end)

    // A stalled result holds.
    `PRU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_sample_value) && $stable(m_channel_index)
        && $stable(m_row_end) && $stable(m_image_end) && $stable(m_bad_filter))

    // A waiting stream byte holds.
    `PRU_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_stream_byte) && $stable(s_image_start))

endmodule

bind png_row_unfilter_top pru_checker u_pru_checker (.*);
